FILE: hw/rtl/mas_pkg.sv
// Shared types and constants for the matrix add / subtract / multiply engine.
// Holds the operation, input mode and result status codes, and the control
// struct between the sequencer and the arithmetic unit. No dependencies.
package mas_pkg;

	localparam int ELEM_W    = 16;
	localparam int PROD_W    = 32;
	localparam int ACC_W     = 40;
	localparam int CFG_DIM_W = 4;
	localparam int IDX_IN_W  = 3;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_BAD = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_LOAD_A = 2'd0,
		MODE_LOAD_B = 2'd1,
		MODE_RUN    = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DIM_ERR = 2'd1,
		ST_OP_ERR  = 2'd2
	} status_t;

	typedef struct packed {
		op_t                  op;
		logic [CFG_DIM_W-1:0] rows_a;
		logic [CFG_DIM_W-1:0] cols_a;
		logic [CFG_DIM_W-1:0] rows_b;
		logic [CFG_DIM_W-1:0] cols_b;
	} cfg_t;

	typedef struct packed {
		op_t  op;
		logic mul_en;
		logic acc_en;
		logic acc_clr;
	} mac_ctl_t;

endpackage

FILE: hw/rtl/matrix_add_sub_multiply.sv
// Matrix add / subtract / multiply engine for signed 16-bit matrices of up to
// MAX_DIM by MAX_DIM. A load beat (mode 0 or 1) writes one element of A or B;
// a run beat (mode 2) then computes the configured operation and emits the
// result row-major with its coordinates, a 40-bit exact value and last set on
// the final beat, or one error beat (status 1 or 2). The block is not ready
// while a run is in progress. One shared multiplier/adder and accumulator does
// all the arithmetic, and each term passes through a store read, a multiply
// and an accumulate step in turn; the output can be held off by out_ready.
// The final result waits in the output register while the next beat is
// already taken. Elements must be loaded before a run reads them.
module matrix_add_sub_multiply #(
	parameter int MAX_DIM = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       mode,
	input  logic [2:0]                       row,
	input  logic [2:0]                       col,
	input  logic signed [15:0]               value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       out_row,
	output logic [2:0]                       out_col,
	output logic signed [39:0]               result_value,
	output logic [1:0]                       status,
	output logic                             last,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [4:0]                       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);

	mas_pkg::cfg_t     cfg;
	mas_pkg::mac_ctl_t mac_ctl;
	logic              we_a, we_b, re;
	logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
	logic signed [mas_pkg::ELEM_W-1:0] rdata_a, rdata_b;
	logic signed [mas_pkg::ACC_W-1:0]  acc;

	mas_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mas_store #(.DEPTH(DEPTH)) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (value),
		.re    (re),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	mas_store #(.DEPTH(DEPTH)) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (value),
		.re    (re),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	mas_mac u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.a   (rdata_a),
		.b   (rdata_b),
		.acc (acc)
	);

	mas_seq #(.MAX_DIM(MAX_DIM)) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.row          (row),
		.col          (col),
		.we_a         (we_a),
		.we_b         (we_b),
		.waddr        (waddr),
		.re           (re),
		.raddr_a      (raddr_a),
		.raddr_b      (raddr_b),
		.mac_ctl      (mac_ctl),
		.acc          (acc),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_row      (out_row),
		.out_col      (out_col),
		.result_value (result_value),
		.status       (status),
		.last         (last)
	);

endmodule

FILE: hw/rtl/mas_cfg.sv
// Configuration register file behind the APB-style write/read port.
// Holds the operation code and the four matrix size registers.
// Depends on mas_pkg.
module mas_cfg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [4:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	output mas_pkg::cfg_t   cfg
);

	localparam logic [2:0] REG_OPERATION = 3'd0;
	localparam logic [2:0] REG_ROWS_A    = 3'd1;
	localparam logic [2:0] REG_COLS_A    = 3'd2;
	localparam logic [2:0] REG_ROWS_B    = 3'd3;
	localparam logic [2:0] REG_COLS_B    = 3'd4;

	mas_pkg::cfg_t cfg_q;
	logic [2:0]    reg_idx;
	logic          wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.op     <= mas_pkg::OP_ADD;
			cfg_q.rows_a <= 4'd1;
			cfg_q.cols_a <= 4'd1;
			cfg_q.rows_b <= 4'd1;
			cfg_q.cols_b <= 4'd1;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_OPERATION: cfg_q.op     <= mas_pkg::op_t'(pwdata[1:0]);
				REG_ROWS_A:    cfg_q.rows_a <= pwdata[3:0];
				REG_COLS_A:    cfg_q.cols_a <= pwdata[3:0];
				REG_ROWS_B:    cfg_q.rows_b <= pwdata[3:0];
				REG_COLS_B:    cfg_q.cols_b <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_OPERATION: prdata = {30'd0, cfg_q.op};
			REG_ROWS_A:    prdata = {28'd0, cfg_q.rows_a};
			REG_COLS_A:    prdata = {28'd0, cfg_q.cols_a};
			REG_ROWS_B:    prdata = {28'd0, cfg_q.rows_b};
			REG_COLS_B:    prdata = {28'd0, cfg_q.cols_b};
			default:       prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/mas_store.sv
// Element store for one matrix: one write port, one read port with
// registered read data. Depends on mas_pkg for the element width.
module mas_store #(
	parameter int DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [$clog2(DEPTH)-1:0]            waddr,
	input  logic signed [mas_pkg::ELEM_W-1:0]   wdata,
	input  logic                                re,
	input  logic [$clog2(DEPTH)-1:0]            raddr,
	output logic signed [mas_pkg::ELEM_W-1:0]   rdata
);

	logic signed [mas_pkg::ELEM_W-1:0] mem_q [DEPTH];
	logic signed [mas_pkg::ELEM_W-1:0] rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/mas_mac.sv
// Shared arithmetic unit: one multiplier/adder stage followed by a 40-bit
// accumulator. Depends on mas_pkg for widths, op codes and the control struct.
module mas_mac (
	input  logic                               clk,
	input  mas_pkg::mac_ctl_t                  ctl,
	input  logic signed [mas_pkg::ELEM_W-1:0]  a,
	input  logic signed [mas_pkg::ELEM_W-1:0]  b,
	output logic signed [mas_pkg::ACC_W-1:0]   acc
);

	localparam int PW = mas_pkg::PROD_W;
	localparam int AW = mas_pkg::ACC_W;

	logic signed [PW-1:0] prod_s1;
	logic signed [AW-1:0] acc_q;

	assign acc = acc_q;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			case (ctl.op)
				mas_pkg::OP_MUL: prod_s1 <= PW'(a) * PW'(b);
				mas_pkg::OP_SUB: prod_s1 <= PW'(a) - PW'(b);
				default:         prod_s1 <= PW'(a) + PW'(b);
			endcase
		end
		if (ctl.acc_en) begin
			acc_q <= (ctl.acc_clr ? AW'(0) : acc_q) + AW'(prod_s1);
		end
	end

endmodule

FILE: hw/rtl/mas_seq.sv
// Sequencer: takes load and run beats, writes the stores, steps the shared
// arithmetic unit over rows, columns and inner terms, and holds the result
// output register. Depends on mas_pkg.
module mas_seq #(
	parameter int MAX_DIM = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mas_pkg::cfg_t                      cfg,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         mode,
	input  logic [mas_pkg::IDX_IN_W-1:0]       row,
	input  logic [mas_pkg::IDX_IN_W-1:0]       col,
	output logic                               we_a,
	output logic                               we_b,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] waddr,
	output logic                               re,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] raddr_a,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] raddr_b,
	output mas_pkg::mac_ctl_t                  mac_ctl,
	input  logic signed [mas_pkg::ACC_W-1:0]   acc,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [mas_pkg::IDX_IN_W-1:0]       out_row,
	output logic [mas_pkg::IDX_IN_W-1:0]       out_col,
	output logic signed [mas_pkg::ACC_W-1:0]   result_value,
	output logic [1:0]                         status,
	output logic                               last
);

	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);
	localparam int OW     = mas_pkg::IDX_IN_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MUL,
		S_ACC,
		S_PUSH
	} state_t;

	// Clamped size minus one, so every bound fits an index.
	function automatic logic [IDX_W-1:0] dim_last(input logic [mas_pkg::CFG_DIM_W-1:0] d);
		logic [IDX_W-1:0] r;
		if (d == '0) begin
			r = '0;
		end else if (int'(d) > MAX_DIM) begin
			r = IDX_W'(MAX_DIM - 1);
		end else begin
			r = IDX_W'(d - 4'd1);
		end
		return r;
	endfunction

	state_t            state_q;
	mas_pkg::op_t      op_q;
	mas_pkg::status_t  st_q;
	logic [IDX_W-1:0]  i_q, j_q, k_q;
	logic [IDX_W-1:0]  i_last_q, j_last_q, k_last_q;
	logic              out_valid_q;
	logic [OW-1:0]     out_row_q, out_col_q;
	logic signed [mas_pkg::ACC_W-1:0] out_val_q;
	mas_pkg::status_t  out_st_q;
	logic              out_last_q;

	logic              accept;
	logic              load_ok;
	logic              slot_free;
	logic              push;
	logic              final_elem;
	logic              is_mul;
	logic [IDX_W-1:0]  ra_m1, ca_m1, rb_m1, cb_m1;
	logic [IDX_W-1:0]  a_col, b_row;

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign load_ok    = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
	assign we_a       = accept && load_ok && (mode == mas_pkg::MODE_LOAD_A);
	assign we_b       = accept && load_ok && (mode == mas_pkg::MODE_LOAD_B);
	assign waddr      = ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);

	assign is_mul     = (op_q == mas_pkg::OP_MUL);
	assign a_col      = is_mul ? k_q : j_q;
	assign b_row      = is_mul ? k_q : i_q;
	assign re         = (state_q == S_READ);
	assign raddr_a    = ADDR_W'(i_q) * ADDR_W'(MAX_DIM) + ADDR_W'(a_col);
	assign raddr_b    = ADDR_W'(b_row) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q);

	assign mac_ctl.op      = op_q;
	assign mac_ctl.mul_en  = (state_q == S_MUL);
	assign mac_ctl.acc_en  = (state_q == S_ACC);
	assign mac_ctl.acc_clr = (k_q == '0);

	assign ra_m1 = dim_last(cfg.rows_a);
	assign ca_m1 = dim_last(cfg.cols_a);
	assign rb_m1 = dim_last(cfg.rows_b);
	assign cb_m1 = dim_last(cfg.cols_b);

	assign slot_free  = !out_valid_q || out_ready;
	assign push       = (state_q == S_PUSH) && slot_free;
	assign final_elem = (st_q != mas_pkg::ST_OK) || ((i_q == i_last_q) && (j_q == j_last_q));

	assign out_valid    = out_valid_q;
	assign out_row      = out_row_q;
	assign out_col      = out_col_q;
	assign result_value = out_val_q;
	assign status       = out_st_q;
	assign last         = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= mas_pkg::OP_ADD;
			st_q        <= mas_pkg::ST_OK;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			i_last_q    <= '0;
			j_last_q    <= '0;
			k_last_q    <= '0;
			out_valid_q <= 1'b0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_val_q   <= '0;
			out_st_q    <= mas_pkg::ST_OK;
			out_last_q  <= 1'b0;
		end else begin
			// A beat leaving the output register is replaced in the same cycle
			// when the sequencer pushes the next one.
			if (out_valid_q && out_ready && !push) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (mode == mas_pkg::MODE_RUN)) begin
						op_q     <= cfg.op;
						i_q      <= '0;
						j_q      <= '0;
						k_q      <= '0;
						i_last_q <= ra_m1;
						if (cfg.op == mas_pkg::OP_MUL) begin
							j_last_q <= cb_m1;
							k_last_q <= ca_m1;
						end else begin
							j_last_q <= ca_m1;
							k_last_q <= '0;
						end
						// The operation check comes before the size check.
						if (cfg.op == mas_pkg::OP_BAD) begin
							st_q    <= mas_pkg::ST_OP_ERR;
							state_q <= S_PUSH;
						end else if ((cfg.op == mas_pkg::OP_MUL) ? (ca_m1 != rb_m1)
								: ((ra_m1 != rb_m1) || (ca_m1 != cb_m1))) begin
							st_q    <= mas_pkg::ST_DIM_ERR;
							state_q <= S_PUSH;
						end else begin
							st_q    <= mas_pkg::ST_OK;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (k_q == k_last_q) begin
						k_q     <= '0;
						state_q <= S_PUSH;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_PUSH: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_st_q    <= st_q;
						out_last_q  <= final_elem;
						if (st_q != mas_pkg::ST_OK) begin
							out_row_q <= '0;
							out_col_q <= '0;
							out_val_q <= '0;
						end else begin
							out_row_q <= OW'(i_q);
							out_col_q <= OW'(j_q);
							out_val_q <= acc;
						end
						if (final_elem) begin
							state_q <= S_IDLE;
						end else begin
							if (j_q == j_last_q) begin
								j_q <= '0;
								i_q <= i_q + 1'b1;
							end else begin
								j_q <= j_q + 1'b1;
							end
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for matrix_add_sub_multiply: load and run beats plus APB writes,
// with every result beat predicted by a behavioral matrix model and compared field by field.
// Depends on mas_pkg and the engine RTL only.
module tb_top;
	import mas_pkg::*;

	localparam int DIM = 8;
	localparam int IDLE_PCT = 28;
	localparam int ITEM_TARGET = 420;
	localparam int SINK_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_PRINTED = 30;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		REG_OPERATION = 3'd0,
		REG_ROWS_A    = 3'd1,
		REG_COLS_A    = 3'd2,
		REG_ROWS_B    = 3'd3,
		REG_COLS_B    = 3'd4
	} reg_index_t;

	typedef struct {
		logic [2:0]         elem_row;
		logic [2:0]         elem_col;
		logic signed [39:0] elem_value;
		status_t            elem_status;
		logic               elem_last;
	} elem_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         mode;
	logic [2:0]         row;
	logic [2:0]         col;
	logic signed [15:0] value;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         out_row;
	logic [2:0]         out_col;
	logic signed [39:0] result_value;
	logic [1:0]         status;
	logic               last;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [4:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	// Model of the engine: register copies and both element stores.
	op_t                op_shadow = OP_ADD;
	logic [3:0]         rows_a_shadow = 4'd1;
	logic [3:0]         cols_a_shadow = 4'd1;
	logic [3:0]         rows_b_shadow = 4'd1;
	logic [3:0]         cols_b_shadow = 4'd1;
	logic signed [15:0] a_store [DIM*DIM];
	logic signed [15:0] b_store [DIM*DIM];
	elem_result_t       expected_elems [$];

	// Which entries the stimulus has written since reset.
	bit a_loaded [DIM*DIM];
	bit b_loaded [DIM*DIM];

	int  send_idle_pct = IDLE_PCT;
	int  sink_idle_pct = IDLE_PCT;
	bit  sink_hold_req = 1'b0;
	int  mismatches = 0;
	int  beats_sent = 0;
	int  runs_sent = 0;
	int  elems_checked = 0;
	int  error_elems_seen = 0;

	matrix_add_sub_multiply uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.row(row),
		.col(col),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_row(out_row),
		.out_col(out_col),
		.result_value(result_value),
		.status(status),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	function automatic int fit_dim(logic [3:0] d);
		if (d == 4'd0)
			return 1;
		if (d > DIM)
			return DIM;
		return int'(d);
	endfunction

	// Expected beats of one run, computed from the stores as they stand at acceptance.
	function automatic void predict_matrix_run();
		elem_result_t e;
		int           ra, ca, rb, cb, nr, nc;
		longint       acc;
		ra = fit_dim(rows_a_shadow);
		ca = fit_dim(cols_a_shadow);
		rb = fit_dim(rows_b_shadow);
		cb = fit_dim(cols_b_shadow);
		e = '{elem_row: 3'd0, elem_col: 3'd0, elem_value: 40'sd0,
			elem_status: ST_OK, elem_last: 1'b1};
		// The operation code is checked ahead of the sizes.
		if (op_shadow == OP_BAD) begin
			e.elem_status = ST_OP_ERR;
			expected_elems.push_back(e);
			return;
		end
		if ((op_shadow == OP_MUL) ? (ca != rb) : (ra != rb || ca != cb)) begin
			e.elem_status = ST_DIM_ERR;
			expected_elems.push_back(e);
			return;
		end
		nr = ra;
		nc = (op_shadow == OP_MUL) ? cb : ca;
		for (int i = 0; i < nr; i++) begin
			for (int j = 0; j < nc; j++) begin
				case (op_shadow)
				OP_MUL: begin
					acc = 0;
					for (int k = 0; k < ca; k++)
						acc += longint'(a_store[i*DIM+k]) * longint'(b_store[k*DIM+j]);
				end
				OP_SUB: acc = longint'(a_store[i*DIM+j]) - longint'(b_store[i*DIM+j]);
				default: acc = longint'(a_store[i*DIM+j]) + longint'(b_store[i*DIM+j]);
				endcase
				e.elem_row = 3'(i);
				e.elem_col = 3'(j);
				e.elem_value = acc[39:0];
				e.elem_last = (i == nr - 1) && (j == nc - 1);
				expected_elems.push_back(e);
			end
		end
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("%t mismatch: %s", $time, msg);
	endtask

	task automatic check_field(string what, logic [39:0] got, logic [39:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", what, got, want));
	endtask

	// Checks result beats first, then updates the model from input beats and register writes.
	always @(posedge clk) begin : scoreboard
		elem_result_t want;
		if (out_valid && out_ready) begin
			if (expected_elems.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want = expected_elems.pop_front();
				elems_checked++;
				if (want.elem_status != ST_OK)
					error_elems_seen++;
				check_field("out_row", 40'(out_row), 40'(want.elem_row));
				check_field("out_col", 40'(out_col), 40'(want.elem_col));
				check_field("result_value", result_value, want.elem_value);
				check_field("status", 40'(status), 40'(want.elem_status));
				check_field("last", 40'(last), 40'(want.elem_last));
			end
		end
		if (in_valid && in_ready) begin
			case (mode)
			MODE_LOAD_A: a_store[row*DIM+col] = value;
			MODE_LOAD_B: b_store[row*DIM+col] = value;
			MODE_RUN: predict_matrix_run();
			default: ;
			endcase
		end
		if (psel && penable && pwrite && pready) begin
			case (paddr[4:2])
			REG_OPERATION: op_shadow = op_t'(pwdata[1:0]);
			REG_ROWS_A: rows_a_shadow = pwdata[3:0];
			REG_COLS_A: cols_a_shadow = pwdata[3:0];
			REG_ROWS_B: rows_b_shadow = pwdata[3:0];
			REG_COLS_B: cols_b_shadow = pwdata[3:0];
			default: ;
			endcase
		end
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				hold_left = SINK_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Valid is left high after a beat; a gap or the end of a burst lowers it.
	task automatic send_beat(logic [1:0] m, logic [2:0] r, logic [2:0] c,
		logic signed [15:0] v);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		mode <= m;
		row <= r;
		col <= c;
		value <= v;
		do @(posedge clk); while (!in_ready);
		if (m == MODE_LOAD_A)
			a_loaded[r*DIM+c] = 1'b1;
		if (m == MODE_LOAD_B)
			b_loaded[r*DIM+c] = 1'b1;
		if (m != MODE_UNUSED)
			beats_sent++;
		if (m == MODE_RUN)
			runs_sent++;
	endtask

	task automatic send_run();
		send_beat(MODE_RUN, 3'($urandom), 3'($urandom), 16'($urandom));
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_elems.size() != 0)
			@(posedge clk);
		// Load beats give no result, so allow the block to finish the last one.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure_engine(op_t op, logic [3:0] ra, logic [3:0] ca,
		logic [3:0] rb, logic [3:0] cb);
		wait_for_results();
		write_reg(REG_OPERATION, 32'(op));
		write_reg(REG_ROWS_A, 32'(ra));
		write_reg(REG_COLS_A, 32'(ca));
		write_reg(REG_ROWS_B, 32'(rb));
		write_reg(REG_COLS_B, 32'(cb));
	endtask

	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(9))
		0: return 16'sh8000;
		1: return 16'sh7fff;
		2: return 16'sh0000;
		3: return 16'shffff;
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_dim();
		case ($urandom_range(9))
		0: return DIM;
		1: return $urandom_range(DIM - 1, 5);
		default: return $urandom_range(4, 1);
		endcase
	endfunction

	// Register value that the engine reads as d: zero stands for one, anything past DIM for DIM.
	function automatic logic [3:0] alias_dim(int d);
		if (d == 1 && $urandom_range(3) == 0)
			return 4'd0;
		if (d == DIM && $urandom_range(1) == 0)
			return 4'($urandom_range(15, DIM + 1));
		return 4'(d);
	endfunction

	// Writes every entry the current sizes can read that is unwritten; with refresh, it also
	// rewrites some of the rest with fresh values and mixes in ignored beats and stray loads.
	task automatic load_operands(bit refresh);
		int ra, ca, rb, cb;
		ra = fit_dim(rows_a_shadow);
		ca = fit_dim(cols_a_shadow);
		rb = fit_dim(rows_b_shadow);
		cb = fit_dim(cols_b_shadow);
		for (int i = 0; i < ra; i++)
			for (int j = 0; j < ca; j++)
				if (!a_loaded[i*DIM+j] || (refresh && $urandom_range(1) == 0))
					send_beat(MODE_LOAD_A, 3'(i), 3'(j), pick_value());
		for (int i = 0; i < rb; i++)
			for (int j = 0; j < cb; j++)
				if (!b_loaded[i*DIM+j] || (refresh && $urandom_range(1) == 0))
					send_beat(MODE_LOAD_B, 3'(i), 3'(j), pick_value());
		if (refresh) begin
			repeat ($urandom_range(2)) begin
				case ($urandom_range(2))
				0: send_beat(MODE_UNUSED, 3'($urandom), 3'($urandom), 16'($urandom));
				1: send_beat(MODE_LOAD_A, 3'($urandom), 3'($urandom), pick_value());
				default: send_beat(MODE_LOAD_B, 3'($urandom), 3'($urandom), pick_value());
				endcase
			end
		end
	endtask

	// Registers at reset give a 1x1 add; an unused mode beat must not disturb anything.
	task automatic test_reset_state();
		send_beat(MODE_LOAD_A, 3'd0, 3'd0, 16'sh7fff);
		send_beat(MODE_LOAD_B, 3'd0, 3'd0, 16'sh7fff);
		send_beat(MODE_UNUSED, 3'd7, 3'd7, 16'sh8000);
		send_run();
		wait_for_results();
	endtask

	task automatic test_error_beats();
		configure_engine(OP_BAD, 4'd1, 4'd1, 4'd1, 4'd1);
		send_run();
		configure_engine(OP_MUL, 4'd1, 4'd2, 4'd3, 4'd1);
		send_run();
		configure_engine(OP_SUB, 4'd2, 4'd1, 4'd1, 4'd1);
		send_run();
		wait_for_results();
	endtask

	// Largest product sum over a full inner dimension, with clamped size registers,
	// then the most negative difference.
	task automatic test_extreme_values();
		configure_engine(OP_MUL, 4'd0, 4'd15, 4'd8, 4'd0);
		for (int k = 0; k < DIM; k++) begin
			send_beat(MODE_LOAD_A, 3'd0, 3'(k), 16'sh8000);
			send_beat(MODE_LOAD_B, 3'(k), 3'd0, 16'sh8000);
		end
		send_run();
		configure_engine(OP_SUB, 4'd1, 4'd1, 4'd1, 4'd1);
		send_beat(MODE_LOAD_B, 3'd0, 3'd0, 16'sh7fff);
		send_run();
		wait_for_results();
	endtask

	// The output is held off while the sender keeps offering, so the engine must stall its input.
	task automatic test_output_backpressure();
		configure_engine(OP_MUL, 4'd3, 4'd3, 4'd3, 4'd3);
		load_operands(1'b0);
		sink_hold_req = 1'b1;
		send_run();
		load_operands(1'b1);
		send_run();
		wait_for_results();
	endtask

	task automatic test_steady_stream();
		send_idle_pct = 0;
		sink_idle_pct = 0;
		configure_engine(OP_MUL, 4'd8, 4'd1, 4'd1, 4'd8);
		load_operands(1'b0);
		send_run();
		configure_engine(OP_ADD, 4'd2, 4'd3, 4'd2, 4'd3);
		load_operands(1'b1);
		send_run();
		send_run();
		wait_for_results();
		send_idle_pct = IDLE_PCT;
		sink_idle_pct = IDLE_PCT;
	endtask

	// Mostly matching sizes with random contents; now and then a broken size pair or bad op.
	task automatic test_random_phases();
		int  ra, ca, rb, cb;
		op_t op;
		while (beats_sent < ITEM_TARGET) begin
			case ($urandom_range(9))
			0: op = OP_BAD;
			1, 2, 3: op = OP_MUL;
			4, 5, 6: op = OP_ADD;
			default: op = OP_SUB;
			endcase
			ra = pick_dim();
			ca = pick_dim();
			rb = (op == OP_MUL) ? ca : ra;
			cb = (op == OP_MUL) ? pick_dim() : ca;
			if ($urandom_range(7) == 0)
				rb = pick_dim();
			configure_engine(op, alias_dim(ra), alias_dim(ca), alias_dim(rb), alias_dim(cb));
			load_operands(1'b1);
			repeat ($urandom_range(3, 1)) begin
				send_run();
				if ($urandom_range(1) == 0)
					load_operands(1'b1);
			end
		end
		wait_for_results();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_LOAD_A;
		row = 3'd0;
		col = 3'd0;
		value = 16'sd0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 5'd0;
		pwdata = 32'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_error_beats();
		test_extreme_values();
		test_output_backpressure();
		test_steady_stream();
		test_random_phases();

		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		$display("ran %0d load and run beats including %0d runs of add, subtract and multiply,",
			beats_sent, runs_sent);
		$display("checked %0d result beats (%0d error beats), %0d mismatches",
			elems_checked, error_elems_seen, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d result beats outstanding", expected_elems.size());
		$display("tb: failure");
		$finish;
	end

endmodule
